// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   localparam int CAPACITY = 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] item_value;
      logic [15:0]        item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic signed [31:0] front_value;
      logic               is_empty;
      logic               is_full;
      logic               dropped;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [15:0]        priority_num;
      logic signed [31:0] value;
   } entry_type;

   typedef struct packed {
      logic               enq;
      logic               deq;
      logic [15:0]        priority_num;
      logic signed [31:0] value;
   } cmd_type;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Bounded priority queue of CAPACITY entries, kept sorted by ascending priority.
// Input channel req_*: one transaction is an enqueue (value with priority) or a
// dequeue of the front entry. Equal priorities leave in arrival order.
// Result channel rsp_*: exactly one transaction per input transaction, giving
// the removed value, the front value after the operation and the empty, full
// and dropped flags. An enqueue into a full queue is dropped and flagged.
// Storage is a row of identical cells; every cell compares its priority with
// the incoming one and shifts toward or away from the front in the same cycle.
// The result is registered and appears in the cycle after the input transaction.
// Throughput: one transaction per cycle while req_stall is low, set by the cell update.
// The output register lets a new input be taken while a result is pending as
// long as that result is taken in the same cycle; while rsp_stall holds a
// pending result, req_stall is high and the queue contents hold.
// Reset empties the queue and clears rsp_valid; stored payload is not cleared.
module sorted_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   entry_type entries     [CAPACITY];
   entry_type entries_nxt [CAPACITY];
   logic      cmps        [CAPACITY];
   cmd_type   cmd;

   logic    req_accept;
   logic    full_now;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign full_now   = entries[CAPACITY-1].valid;

   always_comb begin
      cmd.enq          = req_accept && (req_data.opcode == OP_ENQUEUE) && !full_now;
      cmd.deq          = req_accept && (req_data.opcode == OP_DEQUEUE);
      cmd.priority_num = req_data.item_priority;
      cmd.value        = req_data.item_value;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      l_cmp;
      entry_type l_entry;
      entry_type r_entry;
      if (i == 0) begin : g_first
         assign l_cmp   = 1'b0;
         assign l_entry = '0;
      end else begin : g_mid
         assign l_cmp   = cmps[i-1];
         assign l_entry = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign r_entry = '0;
      end else begin : g_inner
         assign r_entry = entries[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_cmp    (l_cmp),
         .left_entry  (l_entry),
         .right_entry (r_entry),
         .cmp         (cmps[i]),
         .entry       (entries[i]),
         .entry_next  (entries_nxt[i])
      );
   end

   always_comb begin
      rsp_data_in.removed_value = (cmd.deq && entries[0].valid) ? entries[0].value : 32'sd0;
      rsp_data_in.front_value   = entries_nxt[0].valid ? entries_nxt[0].value : 32'sd0;
      rsp_data_in.is_empty      = !entries_nxt[0].valid;
      rsp_data_in.is_full       = entries_nxt[CAPACITY-1].valid;
      rsp_data_in.dropped       = (req_data.opcode == OP_ENQUEUE) && full_now;
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::cmd_type   cmd,
   input  logic               left_cmp,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               cmp,
   output spq_pkg::entry_type entry,
   output spq_pkg::entry_type entry_next
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;

   assign new_entry = '{valid: 1'b1, priority_num: cmd.priority_num, value: cmd.value};

   // new item goes in front of this cell
   assign cmp = !entry_ff.valid || (entry_ff.priority_num > cmd.priority_num);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (cmp) begin
            entry_in = left_cmp ? left_entry : new_entry;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.priority_num <= entry_in.priority_num;
      entry_ff.value        <= entry_in.value;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// ===== rtl/spq_checker.sv =====
module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no result after accepted transaction");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("empty and full together");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> rsp_data.is_full && rsp_data.removed_value == 32'sd0)
      else $error("drop without full queue");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.front_value == 32'sd0)
      else $error("nonzero front on empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
